// ===== rtl/dropblock_mask_builder_defines.svh =====
// ----------------------------------------------------------------------------
// dropblock mask builder assertion macros
// shared concurrent assertion forms, clocked on clk_i, off while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef DROPBLOCK_MASK_BUILDER_DEFINES_SVH
`define DROPBLOCK_MASK_BUILDER_DEFINES_SVH

// property must hold at every edge outside reset
`define DBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression must never be true outside reset
`define DBM_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== rtl/dbm_pkg.sv =====
// ----------------------------------------------------------------------------
// dbm_pkg
// shared constants, codes and control types of the dropblock mask builder
// ----------------------------------------------------------------------------
package dbm_pkg;

  localparam int unsigned MASK_ELEMENTS_DEF  = 65536;
  localparam int unsigned MAX_BLOCK_SIDE_DEF = 16;

  // widest flat element address the seed walk can produce, with margin
  localparam int unsigned FLAT_W     = 30;
  localparam int unsigned ROW_BITS   = 16;
  localparam int unsigned ROW_SEL_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned SIDE_W     = 5;

  typedef enum logic [1:0] {
    MODE_FILL = 2'd0,
    MODE_SEED = 2'd1,
    MODE_READ = 2'd2,
    MODE_NOP  = 2'd3
  } dbm_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BATCH     = 3'd0,
    REG_CHANNELS  = 3'd1,
    REG_HEIGHT    = 3'd2,
    REG_WIDTH     = 3'd3,
    REG_SEED_ROWS = 3'd4,
    REG_SEED_COLS = 3'd5,
    REG_SIDE      = 3'd6,
    REG_LAYOUT    = 3'd7
  } dbm_reg_e;

  localparam logic LAYOUT_NCHW = 1'b0;
  localparam logic LAYOUT_NHWC = 1'b1;

  // effective (clamped) configuration
  typedef struct packed {
    logic [4:0]        batch_n;
    logic [8:0]        chan_n;
    logic [8:0]        height;
    logic [8:0]        width;
    logic [8:0]        seed_rows;
    logic [8:0]        seed_cols;
    logic [SIDE_W-1:0] side;
    logic              layout;
  } dbm_cfg_t;

  typedef struct packed {
    logic take;
    logic clr_start;
    logic clr_step;
    logic rewind;
    logic flag_err;
    logic base_step;
    logic drop_step;
    logic walk_step;
    logic rd_capture;
    logic out_load;
  } dbm_cmd_t;

  typedef struct packed {
    dbm_mode_e mode;
    logic      seed;
    logic      seen;
    logic      side_zero;
    logic      clr_last;
    logic      base_last;
    logic      drop_last;
    logic      out_free;
  } dbm_status_t;

endpackage

// ===== rtl/dbm_mask_store.sv =====
// ----------------------------------------------------------------------------
// dbm_mask_store
// mask bit memory, rows of ROW_BITS bits, bit-enabled write, registered read
// ----------------------------------------------------------------------------
module dbm_mask_store #(
  parameter int unsigned ROWS   = 4096,
  parameter int unsigned ROW_AW = 12
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [ROW_AW-1:0]             wr_row_i,
  input  logic [dbm_pkg::ROW_BITS-1:0]  wr_be_i,
  input  logic                          wr_val_i,
  input  logic [ROW_AW-1:0]             rd_row_i,
  output logic [dbm_pkg::ROW_BITS-1:0]  rd_data_o
);

  logic [dbm_pkg::ROW_BITS-1:0] mem_q [ROWS];
  logic [dbm_pkg::ROW_BITS-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int unsigned b = 0; b < dbm_pkg::ROW_BITS; b++) begin
        if (wr_be_i[b]) begin
          mem_q[wr_row_i][b] <= wr_val_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_row_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/dbm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbm_ctrl
// sequencer: clearing pass, request dispatch, block base, square sweep, reply
// ----------------------------------------------------------------------------
module dbm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dbm_pkg::dbm_status_t status_i,
  output dbm_pkg::dbm_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    S_INIT     = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_DISPATCH = 8'b0000_0100,
    S_FILL     = 8'b0000_1000,
    S_BASE     = 8'b0001_0000,
    S_DROP     = 8'b0010_0000,
    S_READ     = 8'b0100_0000,
    S_OUT      = 8'b1000_0000
  } dbm_state_e;

  dbm_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status_i.mode)
          dbm_pkg::MODE_FILL: begin
            cmd_o.clr_start = 1'b1;
            cmd_o.rewind    = 1'b1;
            state_d         = S_FILL;
          end
          dbm_pkg::MODE_SEED: begin
            if (status_i.seen) begin
              cmd_o.flag_err = 1'b1;
              state_d        = S_OUT;
            end else if (status_i.seed && !status_i.side_zero) begin
              state_d = S_BASE;
            end else begin
              cmd_o.walk_step = 1'b1;
              state_d         = S_OUT;
            end
          end
          dbm_pkg::MODE_READ: state_d = S_READ;
          default:            state_d = S_OUT;
        endcase
      end
      S_FILL: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = S_OUT;
      end
      S_BASE: begin
        cmd_o.base_step = 1'b1;
        if (status_i.base_last) state_d = S_DROP;
      end
      S_DROP: begin
        cmd_o.drop_step = 1'b1;
        if (status_i.drop_last) begin
          cmd_o.walk_step = 1'b1;
          state_d         = S_OUT;
        end
      end
      S_READ: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/dbm_datapath.sv =====
// ----------------------------------------------------------------------------
// dbm_datapath
// seed walk, flat address generation, mask store access and result register
// ----------------------------------------------------------------------------
`include "dropblock_mask_builder_defines.svh"

module dbm_datapath #(
  parameter int unsigned MASK_ELEMENTS = dbm_pkg::MASK_ELEMENTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dbm_pkg::dbm_cfg_t    cfg_i,
  input  dbm_pkg::dbm_mode_e   in_mode_i,
  input  logic                 in_seed_i,
  input  logic [15:0]          in_index_i,
  input  dbm_pkg::dbm_cmd_t    cmd_i,
  output dbm_pkg::dbm_status_t status_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic                 out_bit_o,
  output logic                 out_err_o,
  output logic                 out_done_o
);

  localparam int unsigned FW     = dbm_pkg::FLAT_W;
  localparam int unsigned SW     = dbm_pkg::SIDE_W;
  localparam int unsigned RSW    = dbm_pkg::ROW_SEL_W;
  localparam int unsigned ROWS   = (MASK_ELEMENTS + dbm_pkg::ROW_BITS - 1) / dbm_pkg::ROW_BITS;
  localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [FW-1:0]     STORE_END = FW'(MASK_ELEMENTS);
  localparam logic [ROW_AW-1:0] LAST_ROW  = ROW_AW'(ROWS - 1);

  // accepted request
  dbm_pkg::dbm_mode_e mode_q;
  logic               seed_q;
  logic [15:0]        idx_q;

  // seed walk
  logic [3:0] bpos_q;
  logic [7:0] cpos_q, rpos_q, kpos_q;
  logic       seen_q;

  // address generation
  logic [1:0]    step_q;
  logic [FW-1:0] t_q, row_q, addr_q, rstride_q;
  logic [SW-1:0] di_q, dj_q;
  logic [ROW_AW-1:0] clr_q;

  logic res_bit_q, res_err_q;
  logic out_valid_q, out_bit_q, out_err_q, out_done_q;

  logic [FW-1:0]   mul_a, t_d, cstride, idx_ext;
  logic [8:0]      mul_m;
  logic [7:0]      add_v;
  logic [FW+8:0]   prod;
  logic [17:0]     wc;
  logic            col_wrap, row_wrap, ch_wrap, b_wrap;
  logic            addr_ok, idx_ok, j_last, i_last, out_free;
  logic            mem_wr_en, mem_wr_val;
  logic [ROW_AW-1:0]            mem_wr_row, mem_rd_row;
  logic [dbm_pkg::ROW_BITS-1:0] mem_wr_be, mem_rd_data;

  // one multiply-add per base step, order set by layout
  always_comb begin
    case (step_q)
      2'd0: begin
        mul_a = FW'(bpos_q);
        mul_m = (cfg_i.layout == dbm_pkg::LAYOUT_NHWC) ? cfg_i.height : cfg_i.chan_n;
        add_v = (cfg_i.layout == dbm_pkg::LAYOUT_NHWC) ? rpos_q : cpos_q;
      end
      2'd1: begin
        mul_a = t_q;
        mul_m = (cfg_i.layout == dbm_pkg::LAYOUT_NHWC) ? cfg_i.width : cfg_i.height;
        add_v = (cfg_i.layout == dbm_pkg::LAYOUT_NHWC) ? kpos_q : rpos_q;
      end
      default: begin
        mul_a = t_q;
        mul_m = (cfg_i.layout == dbm_pkg::LAYOUT_NHWC) ? cfg_i.chan_n : cfg_i.width;
        add_v = (cfg_i.layout == dbm_pkg::LAYOUT_NHWC) ? cpos_q : kpos_q;
      end
    endcase
  end

  assign prod    = (FW+9)'(mul_a) * (FW+9)'(mul_m);
  assign t_d     = prod[FW-1:0] + FW'(add_v);
  assign wc      = 18'(cfg_i.width) * 18'(cfg_i.chan_n);
  assign cstride = (cfg_i.layout == dbm_pkg::LAYOUT_NHWC) ? FW'(cfg_i.chan_n) : FW'(1);
  assign idx_ext = FW'(idx_q);

  assign addr_ok = addr_q < STORE_END;
  assign idx_ok  = idx_ext < STORE_END;
  assign j_last  = dj_q == (cfg_i.side - SW'(1));
  assign i_last  = di_q == (cfg_i.side - SW'(1));

  assign col_wrap = !((9'(kpos_q) + 9'd1) < cfg_i.seed_cols);
  assign row_wrap = !((9'(rpos_q) + 9'd1) < cfg_i.seed_rows);
  assign ch_wrap  = !((9'(cpos_q) + 9'd1) < cfg_i.chan_n);
  assign b_wrap   = !((5'(bpos_q) + 5'd1) < cfg_i.batch_n);

  assign out_free = !out_valid_q || m_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      mode_q <= in_mode_i;
      seed_q <= in_seed_i;
      idx_q  <= in_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q <= '0;
      cpos_q <= '0;
      rpos_q <= '0;
      kpos_q <= '0;
      seen_q <= 1'b0;
    end else if (cmd_i.rewind) begin
      bpos_q <= '0;
      cpos_q <= '0;
      rpos_q <= '0;
      kpos_q <= '0;
      seen_q <= 1'b0;
    end else if (cmd_i.walk_step) begin
      if (!col_wrap) begin
        kpos_q <= kpos_q + 8'd1;
      end else begin
        kpos_q <= '0;
        if (!row_wrap) begin
          rpos_q <= rpos_q + 8'd1;
        end else begin
          rpos_q <= '0;
          if (!ch_wrap) begin
            cpos_q <= cpos_q + 8'd1;
          end else begin
            cpos_q <= '0;
            if (!b_wrap) begin
              bpos_q <= bpos_q + 4'd1;
            end else begin
              bpos_q <= '0;
              seen_q <= 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      di_q   <= '0;
      dj_q   <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.take) begin
        step_q <= '0;
        di_q   <= '0;
        dj_q   <= '0;
      end else if (cmd_i.base_step) begin
        step_q <= step_q + 2'd1;
      end else if (cmd_i.drop_step) begin
        if (j_last) begin
          dj_q <= '0;
          di_q <= di_q + SW'(1);
        end else begin
          dj_q <= dj_q + SW'(1);
        end
      end
      if (cmd_i.clr_start) begin
        clr_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_q <= (clr_q == LAST_ROW) ? '0 : clr_q + ROW_AW'(1);
      end
    end
  end

  // row base advances by the row stride, elements by the column stride
  always_ff @(posedge clk_i) begin
    if (cmd_i.base_step) begin
      t_q <= t_d;
      if (step_q == 2'd0) begin
        rstride_q <= (cfg_i.layout == dbm_pkg::LAYOUT_NHWC) ? FW'(wc) : FW'(cfg_i.width);
      end
      if (step_q == 2'd2) begin
        row_q  <= t_d;
        addr_q <= t_d;
      end
    end else if (cmd_i.drop_step) begin
      if (j_last) begin
        row_q  <= row_q + rstride_q;
        addr_q <= row_q + rstride_q;
      end else begin
        addr_q <= addr_q + cstride;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      res_bit_q <= 1'b0;
      res_err_q <= 1'b0;
    end else if (cmd_i.flag_err) begin
      res_err_q <= 1'b1;
    end else if (cmd_i.drop_step && !addr_ok) begin
      res_err_q <= 1'b1;
    end else if (cmd_i.rd_capture) begin
      res_bit_q <= idx_ok & mem_rd_data[idx_q[RSW-1:0]];
      res_err_q <= !idx_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_bit_q  <= res_bit_q;
      out_err_q  <= res_err_q;
      out_done_q <= seen_q;
    end
  end

  assign mem_wr_en  = cmd_i.clr_step || (cmd_i.drop_step && addr_ok);
  assign mem_wr_val = cmd_i.clr_step;
  assign mem_wr_row = cmd_i.clr_step ? clr_q : addr_q[ROW_AW+RSW-1:RSW];
  assign mem_wr_be  = cmd_i.clr_step ? '1 :
                      (dbm_pkg::ROW_BITS'(1) << addr_q[RSW-1:0]);
  assign mem_rd_row = idx_ext[ROW_AW+RSW-1:RSW];

  dbm_mask_store #(
    .ROWS  (ROWS),
    .ROW_AW(ROW_AW)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (mem_wr_en),
    .wr_row_i (mem_wr_row),
    .wr_be_i  (mem_wr_be),
    .wr_val_i (mem_wr_val),
    .rd_row_i (mem_rd_row),
    .rd_data_o(mem_rd_data)
  );

  assign status_o.mode      = mode_q;
  assign status_o.seed      = seed_q;
  assign status_o.seen      = seen_q;
  assign status_o.side_zero = cfg_i.side == '0;
  assign status_o.clr_last  = clr_q == LAST_ROW;
  assign status_o.base_last = step_q == 2'd2;
  assign status_o.drop_last = i_last && j_last;
  assign status_o.out_free  = out_free;

  assign m_valid_o  = out_valid_q;
  assign out_bit_o  = out_bit_q;
  assign out_err_o  = out_err_q;
  assign out_done_o = out_done_q;

  `DBM_ASSERT(a_load_into_free, cmd_i.out_load |-> out_free, "result loaded over a pending one")
  `DBM_ASSERT(a_seen_at_origin, seen_q |-> (bpos_q == '0 && cpos_q == '0 && rpos_q == '0 && kpos_q == '0), "walk not rewound after last seed")
  `DBM_ASSERT(a_fill_rewinds, cmd_i.rewind |=> !seen_q, "fill did not clear seeds done")
  `DBM_ASSERT_NEVER(a_write_clash, cmd_i.clr_step && cmd_i.drop_step, "clear sweep and drop collide")

endmodule

// ===== rtl/dropblock_mask_builder.sv =====
// ----------------------------------------------------------------------------
// dropblock_mask_builder
// dropblock 2d mask store with seed walk, block drop and bit read
// ----------------------------------------------------------------------------
// requests enter on s_axis (tuser = mode, tdata = seed bit and read index),
// one reply per request leaves on m_axis; registers are written on the cfg
// channel, which is always ready; the user must write them only while no
// request is in flight, which the block does not enforce. one request is
// worked at a time; from acceptance to reply valid it passes through:
//   idle mode, seed without drop, seed past the last position: dispatch, reply
//   read mask bit: dispatch, bit capture from the registered store read, reply
//   block drop: dispatch, block base, sweep (one mask bit cleared a cycle), reply
//   fill: dispatch, store sweep (one 16-bit store row set a cycle), reply
// a new request is taken in the cycle after the reply is registered, and never
// while one is being worked. after reset the store is swept to all ones, row
// by row, with s_axis_tready low; cfg writes are taken.
// the reply sits in an output register; while the receiver stalls the next
// request can still be accepted and worked, and waits for the slot to free.
// ----------------------------------------------------------------------------
module dropblock_mask_builder #(
  parameter int unsigned MASK_ELEMENTS  = dbm_pkg::MASK_ELEMENTS_DEF,
  parameter int unsigned MAX_BLOCK_SIDE = dbm_pkg::MAX_BLOCK_SIDE_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [23:0]                      s_axis_tdata,  // seed_bit, read_index[15:0]
  input  logic [1:0]                       s_axis_tuser,  // mode[1:0]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // mask_bit
  output logic [1:0]                       m_axis_tuser,  // range_error, seeds_done
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [dbm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [dbm_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [4:0] batch_q, side_q;
  logic [8:0] chan_q, height_q, width_q, srows_q, scols_q;
  logic       layout_q;

  dbm_pkg::dbm_cfg_t    cfg;
  dbm_pkg::dbm_cmd_t    cmd;
  dbm_pkg::dbm_status_t status;
  logic                 out_bit, out_err, out_done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q  <= 5'd1;
      chan_q   <= 9'd1;
      height_q <= 9'd1;
      width_q  <= 9'd1;
      srows_q  <= 9'd1;
      scols_q  <= 9'd1;
      side_q   <= 5'd1;
      layout_q <= dbm_pkg::LAYOUT_NCHW;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dbm_pkg::REG_BATCH:     batch_q  <= cfg_data_i[4:0];
        dbm_pkg::REG_CHANNELS:  chan_q   <= cfg_data_i;
        dbm_pkg::REG_HEIGHT:    height_q <= cfg_data_i;
        dbm_pkg::REG_WIDTH:     width_q  <= cfg_data_i;
        dbm_pkg::REG_SEED_ROWS: srows_q  <= cfg_data_i;
        dbm_pkg::REG_SEED_COLS: scols_q  <= cfg_data_i;
        dbm_pkg::REG_SIDE:      side_q   <= cfg_data_i[4:0];
        dbm_pkg::REG_LAYOUT:    layout_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // counts of zero act as one, counts above the range saturate
  function automatic logic [8:0] clamp_count(input logic [8:0] v);
    logic [8:0] r;
    r = v;
    if (v == 9'd0)   r = 9'd1;
    if (v > 9'd256)  r = 9'd256;
    return r;
  endfunction

  always_comb begin
    cfg.batch_n   = (batch_q == 5'd0) ? 5'd1 : ((batch_q > 5'd16) ? 5'd16 : batch_q);
    cfg.chan_n    = clamp_count(chan_q);
    cfg.height    = clamp_count(height_q);
    cfg.width     = clamp_count(width_q);
    cfg.seed_rows = clamp_count(srows_q);
    cfg.seed_cols = clamp_count(scols_q);
    cfg.side      = (32'(side_q) > MAX_BLOCK_SIDE) ? dbm_pkg::SIDE_W'(MAX_BLOCK_SIDE) : side_q;
    cfg.layout    = layout_q;
  end

  dbm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  dbm_datapath #(
    .MASK_ELEMENTS(MASK_ELEMENTS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_mode_i (dbm_pkg::dbm_mode_e'(s_axis_tuser)),
    .in_seed_i (s_axis_tdata[0]),
    .in_index_i(s_axis_tdata[16:1]),
    .cmd_i     (cmd),
    .status_o  (status),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .out_bit_o (out_bit),
    .out_err_o (out_err),
    .out_done_o(out_done)
  );

  assign m_axis_tdata = {7'd0, out_bit};
  assign m_axis_tuser = {out_done, out_err};

endmodule
